>>> rtl/core/dwts_pkg.sv
// Package for the dual-window timed statistics block.
// Holds the shared widths, kind codes, the controller/datapath command struct and the reset period.
package dwts_pkg;

   localparam int PeriodWidth  = 40;
   localparam int EffWidth     = 41;
   localparam int TimeWidth    = 63;
   localparam int DataWidth    = 64;
   localparam int AddrWidth    = 1;
   localparam logic [PeriodWidth-1:0] PeriodReset = 40'd1000000000;

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_ACCOUNT = 2'd1;

   localparam logic [AddrWidth-1:0] REG_PERIOD = 1'b0;

   typedef struct packed {
      logic load;      // capture the request and do the start update
      logic mod_start; // start remainder for window in mod_win
      logic mod_win;
      logic mod_done;  // apply expiry for mod_win
      logic acc;       // account and choose older window
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need0;
      logic need1;
      logic iter_busy;
      logic scale_busy; // scaled period is being recomputed after a write
   } sts_type;

endpackage

>>> rtl/core/dwts_datapath.sv
// Datapath: window registers, shared iterative 64-bit divider and result register.
// Depends on dwts_pkg.
module dwts_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  dwts_pkg::cmd_type       cmd,
   output dwts_pkg::sts_type       sts,
   input  logic [1:0]              in_kind,
   input  logic [62:0]             in_time,
   input  logic [63:0]             in_value,
   input  logic [39:0]             period,
   output logic [63:0]             o_min,
   output logic [63:0]             o_max,
   output logic [63:0]             o_mean,
   output logic [63:0]             o_sum,
   output logic [40:0]             o_elapsed
);

   logic [63:0] dl_ff [2];
   logic [63:0] mn_ff [2];
   logic [63:0] mx_ff [2];
   logic [63:0] sm_ff [2];
   logic [63:0] ct_ff [2];
   logic        old_ff;
   logic [40:0] eff_ff;
   logic [1:0]  kind_ff;
   logic [62:0] now_ff;
   logic [63:0] val_ff;

   // Restoring divider state.
   logic [63:0] quo_ff;
   logic [63:0] rem_ff;
   logic [63:0] dvs_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff;
   logic [64:0] trial;

   // Period scaling by four thirds. The value 4*period is folded as
   // r = r/4 + r%4 while r/4 is added to the quotient, which keeps
   // 4*period = 3*q + r; a final r of three adds one more.
   logic [39:0] seen_ff;
   logic [42:0] red_ff;
   logic [40:0] quo3_ff;
   logic [40:0] scaled_ff;
   logic        scale_run_ff;
   logic        period_new;

   assign trial   = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};

   assign period_new = (period != seen_ff);

   assign sts.need0      = (dl_ff[0] <= {1'b0, now_ff});
   assign sts.need1      = (dl_ff[1] <= {1'b0, now_ff});
   assign sts.iter_busy  = busy_ff;
   assign sts.scale_busy = scale_run_ff || period_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= dwts_pkg::PeriodReset;
         red_ff       <= '0;
         quo3_ff      <= '0;
         scaled_ff    <= 41'(({3'b0, dwts_pkg::PeriodReset} << 2) / 3);
         scale_run_ff <= 1'b0;
      end else if (period_new) begin
         seen_ff      <= period;
         red_ff       <= {1'b0, period, 2'b00};
         quo3_ff      <= '0;
         scale_run_ff <= 1'b1;
      end else if (scale_run_ff) begin
         if (red_ff > 43'd3) begin
            quo3_ff <= quo3_ff + red_ff[42:2];
            red_ff  <= {2'b00, red_ff[42:2]} + {41'd0, red_ff[1:0]};
         end else begin
            scaled_ff    <= quo3_ff + {40'd0, (red_ff == 43'd3)};
            scale_run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         old_ff  <= 1'b0;
         eff_ff  <= 41'(({3'b0, dwts_pkg::PeriodReset} << 2) / 3);
         for (int w = 0; w < 2; w++) begin
            dl_ff[w] <= '0;
            mn_ff[w] <= '1;
            mx_ff[w] <= '0;
            sm_ff[w] <= '0;
            ct_ff[w] <= '0;
         end
      end else begin
         if (cmd.load) begin
            kind_ff <= in_kind;
            now_ff  <= in_time;
            val_ff  <= in_value;
            if (in_kind == dwts_pkg::KIND_START) begin
               eff_ff <= scaled_ff;
               old_ff <= 1'b0;
               dl_ff[0] <= {1'b0, in_time} + 64'(scaled_ff >> 1);
               dl_ff[1] <= {1'b0, in_time} + 64'(scaled_ff);
               for (int w = 0; w < 2; w++) begin
                  mn_ff[w] <= '1;
                  mx_ff[w] <= '0;
                  sm_ff[w] <= '0;
                  ct_ff[w] <= '0;
               end
            end
         end
         if (cmd.mod_start) begin
            quo_ff  <= {1'b0, now_ff} - dl_ff[cmd.mod_win];
            rem_ff  <= '0;
            dvs_ff  <= 64'(eff_ff);
            cnt_ff  <= 7'd64;
            busy_ff <= (eff_ff != '0);
         end else if (cmd.div_start) begin
            quo_ff  <= sm_ff[old_ff];
            rem_ff  <= '0;
            dvs_ff  <= ct_ff[old_ff];
            cnt_ff  <= 7'd64;
            busy_ff <= (ct_ff[old_ff] != '0);
            if (ct_ff[old_ff] == '0) quo_ff <= '0;
         end else if (busy_ff) begin
            if (!trial[64]) begin
               rem_ff <= trial[63:0];
               quo_ff <= {quo_ff[62:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[62:0], quo_ff[63]};
               quo_ff <= {quo_ff[62:0], 1'b0};
            end
            cnt_ff  <= cnt_ff - 7'd1;
            busy_ff <= (cnt_ff != 7'd1);
         end
         if (cmd.mod_done) begin
            mn_ff[cmd.mod_win] <= '1;
            mx_ff[cmd.mod_win] <= '0;
            sm_ff[cmd.mod_win] <= '0;
            ct_ff[cmd.mod_win] <= '0;
            dl_ff[cmd.mod_win] <= {1'b0, now_ff} +
               ((eff_ff == '0) ? 64'd0 : (64'(eff_ff) - rem_ff));
         end
         if (cmd.acc) begin
            old_ff <= (dl_ff[0] < dl_ff[1]) ? 1'b0 : 1'b1;
            if (kind_ff == dwts_pkg::KIND_ACCOUNT) begin
               for (int w = 0; w < 2; w++) begin
                  sm_ff[w] <= sm_ff[w] + val_ff;
                  ct_ff[w] <= ct_ff[w] + 64'd1;
                  if (val_ff < mn_ff[w]) mn_ff[w] <= val_ff;
                  if (val_ff > mx_ff[w]) mx_ff[w] <= val_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_min     <= (mn_ff[old_ff] != '1) ? mn_ff[old_ff] : '0;
         o_max     <= mx_ff[old_ff];
         o_mean    <= quo_ff;
         o_sum     <= sm_ff[old_ff];
         o_elapsed <= 41'(64'(eff_ff) - (dl_ff[old_ff] - {1'b0, now_ff}));
      end
   end

endmodule

>>> rtl/core/dwts_ctrl.sv
// Controller state machine sequencing expiry, accounting, mean and output.
// Depends on dwts_pkg.
module dwts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                rsp_free,
   input  logic                rsp_take,
   input  dwts_pkg::sts_type   sts,
   output dwts_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHK, S_MOD, S_ACC, S_DIV, S_OUT
   } state_type;

   state_type state_ff;
   logic      win_ff;
   logic      started_ff;
   logic      valid_ff;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load    = req_fire;
      cmd.mod_win = win_ff;
      case (state_ff)
         S_CHK: begin
            cmd.mod_start = win_ff ? sts.need1 : sts.need0;
         end
         S_MOD: begin
            cmd.mod_done = started_ff && !sts.iter_busy;
         end
         S_ACC:   cmd.acc = 1'b1;
         S_DIV:   cmd.div_start = !started_ff;
         S_OUT:   cmd.out_load = rsp_free;
         default: cmd = cmd;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         win_ff     <= 1'b0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (rsp_take) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_CHK;
                  win_ff   <= 1'b0;
               end
            end
            S_CHK: begin
               if (cmd.mod_start) begin
                  state_ff   <= S_MOD;
                  started_ff <= 1'b1;
               end else if (win_ff) begin
                  state_ff <= S_ACC;
               end else begin
                  win_ff <= 1'b1;
               end
            end
            S_MOD: begin
               if (cmd.mod_done) begin
                  started_ff <= 1'b0;
                  if (win_ff) begin
                     state_ff <= S_ACC;
                  end else begin
                     state_ff <= S_CHK;
                     win_ff   <= 1'b1;
                  end
               end
            end
            S_ACC: state_ff <= S_DIV;
            S_DIV: begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
               end else if (!sts.iter_busy) begin
                  started_ff <= 1'b0;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_free) begin
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/core/dual_window_timed_statistics.sv
// Top level of the dual-window timed statistics block.
// Depends on dwts_pkg, dwts_ctrl and dwts_datapath.
//
//   Channel   Direction  Payload
//   req_      in         tdata: kind, time_now, sample_value
//   rsp_      out        tdata: min, max, mean, total, elapsed
//   csr_      in         APB register requested_period at address 0
//
// After a request is taken, each window is checked in turn; when it has
// expired it needs a 64-step remainder on the shared restoring divider.
// Then the accounting step runs, the mean is computed on the same divider
// (no division for an empty window) and the result is loaded. A new
// request is taken only when the controller is idle. The result register
// may hold the previous result until it is taken, which stalls the load.
// After a period write the scaled period is recomputed, and no request is
// taken while this runs. Reset is synchronous and active high.
module dual_window_timed_statistics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] kind, [64:2] time_now, [128:65] sample_value, rest zero
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] min_value, [127:64] max_value, [191:128] mean_value,
   // [255:192] window_total, [296:256] elapsed_ns, rest zero
   output logic [303:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   dwts_pkg::cmd_type cmd;
   dwts_pkg::sts_type sts;
   logic        busy;
   logic        req_fire;
   logic        rsp_take;
   logic [39:0] period_ff;
   logic [63:0] o_min, o_max, o_mean, o_sum;
   logic [40:0] o_elapsed;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == dwts_pkg::REG_PERIOD) ? {24'd0, period_ff} : 64'd0;

   // The register is written on the access phase of an APB write.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= dwts_pkg::PeriodReset;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[3] == dwts_pkg::REG_PERIOD) begin
         period_ff <= csr_pwdata[39:0];
      end
   end

   assign req_tready = !busy && !sts.scale_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;

   dwts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_free  (!rsp_tvalid || rsp_tready),
      .rsp_take  (rsp_take),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_tvalid)
   );

   dwts_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_kind   (req_tdata[1:0]),
      .in_time   (req_tdata[64:2]),
      .in_value  (req_tdata[128:65]),
      .period    (period_ff),
      .o_min     (o_min),
      .o_max     (o_max),
      .o_mean    (o_mean),
      .o_sum     (o_sum),
      .o_elapsed (o_elapsed)
   );

   assign rsp_tdata = {7'd0, o_elapsed, o_sum, o_mean, o_max, o_min};

`ifndef SYNTHESIS
   // A request is never taken while one is still being worked on.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request taken while busy");
   // A result becomes valid only as the controller returns to idle.
   a_result_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !busy) else $error("result raised while busy");
   // The result register only loads when the output side is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready)) else $error("result overwritten");
`endif

endmodule
